>>> sv/ghac_pkg.sv
package ghac_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    // GCM reduction constant, bit-reflected: 0xE1 followed by zeros
    localparam logic [63:0] GHASH_REDUCE_HIGH = 64'hE100000000000000;

    typedef enum logic [0:0] {
        CFG_HASH_KEY_HIGH = 1'b0,
        CFG_HASH_KEY_LOW  = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
        logic        last_block;
    } in_word_t;

    typedef struct packed {
        logic [63:0] hash_high;
        logic [63:0] hash_low;
        logic        hash_final;
    } out_word_t;

    // GF(2^128) product in GCM bit order (bit 127 holds the x^0 coefficient).
    function automatic logic [127:0] gf128_mul(logic [127:0] a, logic [127:0] b);
        logic [127:0] ar;
        logic [127:0] br;
        logic [254:0] c;
        logic [126:0] h;
        logic [134:0] t;
        logic [6:0]   g;
        logic [127:0] r;
        logic [127:0] z;
        for (int i = 0; i < 128; i++)
        begin
            ar[i] = a[127-i];
            br[i] = b[127-i];
        end
        c = '0;
        for (int i = 0; i < 128; i++)
        begin
            for (int j = 0; j < 128; j++)
            begin
                c[i+j] = c[i+j] ^ (ar[i] & br[j]);
            end
        end
        // fold x^128 and above twice through x^128 = x^7 + x^2 + x + 1
        h = c[254:128];
        t = {7'b0, c[127:0]};
        for (int p = 0; p < 8; p++)
        begin
            if (GHASH_REDUCE_HIGH[63-p])
            begin
                t = t ^ ({8'b0, h} << p);
            end
        end
        g = t[134:128];
        r = t[127:0];
        for (int p = 0; p < 8; p++)
        begin
            if (GHASH_REDUCE_HIGH[63-p])
            begin
                r = r ^ ({121'b0, g} << p);
            end
        end
        for (int i = 0; i < 128; i++)
        begin
            z[i] = r[127-i];
        end
        return z;
    endfunction

endpackage

>>> sv/ghac_queue.sv
module ghac_queue #(
    parameter int unsigned DEPTH = ghac_pkg::QUEUE_DEPTH,
    parameter type word_t = ghac_pkg::in_word_t
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  word_t wdata,
    output logic  full,
    input  logic  pop,
    output word_t rdata,
    output logic  empty
);

    localparam int unsigned PtrW = $clog2(DEPTH);
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    word_t           mem_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == FullCnt);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> sv/ghac_back.sv
module ghac_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  ghac_pkg::cfg_index_t  cfg_index,
    input  logic [63:0]           cfg_data,
    input  ghac_pkg::in_word_t    cmd,
    input  logic                  cmd_valid,
    output logic                  cmd_take,
    output ghac_pkg::out_word_t   res,
    input  logic                  res_room
);

    logic [127:0] key_reg, key_next;
    logic [127:0] acc_reg, acc_next;
    logic [127:0] prod;

    assign cmd_take = cmd_valid && res_room;
    assign prod     = ghac_pkg::gf128_mul(acc_reg ^ {cmd.block_high, cmd.block_low}, key_reg);

    assign res.hash_high  = prod[127:64];
    assign res.hash_low   = prod[63:0];
    assign res.hash_final = cmd.last_block;

    always_comb
    begin
        key_next = key_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                ghac_pkg::CFG_HASH_KEY_HIGH: key_next[127:64] = cfg_data;
                ghac_pkg::CFG_HASH_KEY_LOW:  key_next[63:0]   = cfg_data;
                default:                     key_next         = key_reg;
            endcase
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd_take)
        begin
            acc_next = cmd.last_block ? '0 : prod;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
            acc_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
            acc_reg <= acc_next;
        end
    end

endmodule

>>> sv/ghash_accumulator_top.sv
// GHASH accumulator: one 128-bit block per word in, one running hash per word out, with
// H loaded in two 64-bit halves of the key register. H is to be loaded while the block is
// idle; the block itself does not enforce this. It takes one word per cycle for as long
// as results are popped; the accumulate-and-multiply around the accumulator is
// combinational, so consecutive blocks of a message follow each other back to back. A
// pushed word is stored in the input queue; its product is formed from the head of that
// queue and registered into the result queue, where it can then be popped. The final block
// of a message is flagged in hash_final and the accumulator restarts from zero after it.
module ghash_accumulator_top #(
    parameter int unsigned QUEUE_DEPTH = ghac_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  ghac_pkg::cfg_index_t cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic                 push,
    input  ghac_pkg::in_word_t   item,
    output logic                 full,
    input  logic                 pop,
    output ghac_pkg::out_word_t  result,
    output logic                 empty
);

    ghac_pkg::in_word_t  cmd;
    ghac_pkg::out_word_t res;
    logic                cmd_empty;
    logic                cmd_take;
    logic                res_full;

    ghac_queue #(
        .DEPTH  (QUEUE_DEPTH),
        .word_t (ghac_pkg::in_word_t)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (item),
        .full  (full),
        .pop   (cmd_take),
        .rdata (cmd),
        .empty (cmd_empty)
    );

    ghac_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .cmd_valid (!cmd_empty),
        .cmd_take  (cmd_take),
        .res       (res),
        .res_room  (!res_full)
    );

    ghac_queue #(
        .DEPTH  (QUEUE_DEPTH),
        .word_t (ghac_pkg::out_word_t)
    ) u_result (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_take),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

>>> tb/tb_ghash_accumulator_top.sv
module tb_ghash_accumulator_top;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned LONG_HOLD   = 90;
    localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    ghac_pkg::cfg_index_t cfg_index = ghac_pkg::CFG_HASH_KEY_HIGH;
    logic [63:0]          cfg_data = '0;
    logic                 push = 1'b0;
    ghac_pkg::in_word_t   item = '0;
    logic                 full;
    logic                 pop = 1'b0;
    ghac_pkg::out_word_t  result;
    logic                 empty;

    // predictor state
    logic [127:0]        hash_key = '0;
    logic [127:0]        running_sum = '0;
    ghac_pkg::out_word_t expected_hashes[$];

    ghac_pkg::in_word_t  pending_words[$];
    int unsigned  queued_count = 0;
    int unsigned  accepted_count = 0;
    logic         word_taken = 1'b0;
    int unsigned  send_gap = 0;
    int unsigned  hold_left = 0;
    bit           idling_on = 1'b1;
    bit           stall_request = 1'b0;
    int unsigned  error_count = 0;
    int unsigned  cycle_count = 0;

    ghash_accumulator_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .item      (item),
        .full      (full),
        .pop       (pop),
        .result    (result),
        .empty     (empty)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // GF(2^128) product, GCM bit order: bit 127 is the x^0 coefficient
    function automatic logic [127:0] gcm_product(logic [127:0] x, logic [127:0] y);
        logic [127:0] z;
        logic [127:0] v;
        logic         carry;
        z = '0;
        v = y;
        for (int k = 0; k < 128; k++)
        begin
            if (x[127-k])
            begin
                z = z ^ v;
            end
            carry = v[0];
            v = v >> 1;
            if (carry)
            begin
                v[127:64] = v[127:64] ^ ghac_pkg::GHASH_REDUCE_HIGH;
            end
        end
        return z;
    endfunction

    function automatic logic [63:0] pick_half();
        int unsigned sel;
        sel = $urandom_range(0, 15);
        if (sel == 0)
        begin
            return '0;
        end
        else if (sel == 1)
        begin
            return ALL_ONES;
        end
        return {$urandom(), $urandom()};
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h (cycle %0d)", what, got, want, cycle_count);
        error_count++;
    endtask

    task automatic queue_block(logic [63:0] hi, logic [63:0] lo, logic last);
        ghac_pkg::in_word_t w;
        w.block_high = hi;
        w.block_low  = lo;
        w.last_block = last;
        pending_words.push_back(w);
        queued_count++;
    endtask

    // registers change only with nothing in flight
    task automatic load_hash_key(logic [127:0] key);
        hash_key = key;
        cfg_write <= 1'b1;
        cfg_index <= ghac_pkg::CFG_HASH_KEY_HIGH;
        cfg_data  <= key[127:64];
        @(negedge clk);
        cfg_index <= ghac_pkg::CFG_HASH_KEY_LOW;
        cfg_data  <= key[63:0];
        @(negedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (accepted_count != queued_count || expected_hashes.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (3) @(negedge clk);
    endtask

    // messages of random length; the phase may end mid-message
    task automatic queue_messages(int unsigned n);
        int unsigned count;
        int unsigned len;
        count = 0;
        while (count < n)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
            for (int i = 0; i < len && count < n; i++)
            begin
                queue_block(pick_half(), pick_half(), i == len - 1);
                count++;
            end
        end
    endtask

    // sender
    always @(negedge clk)
    begin
        if (word_taken)
        begin
            pending_words.delete(0);
        end
        if (push && !word_taken)
        begin
            push <= 1'b1;
        end
        else if (send_gap > 0)
        begin
            send_gap--;
            push <= 1'b0;
        end
        else if (pending_words.size() == 0)
        begin
            push <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 5) == 0)
        begin
            send_gap = $urandom_range(1, 12) - 1;
            push <= 1'b0;
        end
        else
        begin
            push <= 1'b1;
            item <= pending_words[0];
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (stall_request)
        begin
            stall_request = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 5) == 0)
        begin
            hold_left = $urandom_range(1, 12) - 1;
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        logic [127:0]        folded;
        logic [127:0]        product;
        ghac_pkg::out_word_t want;
        if (rst_n)
        begin
            word_taken <= push && !full;
            if (push && !full)
            begin
                folded  = running_sum ^ {item.block_high, item.block_low};
                product = gcm_product(folded, hash_key);
                want.hash_high  = product[127:64];
                want.hash_low   = product[63:0];
                want.hash_final = item.last_block;
                expected_hashes.push_back(want);
                running_sum = item.last_block ? '0 : product;
                accepted_count++;
            end
            if (pop && !empty)
            begin
                if (expected_hashes.size() == 0)
                begin
                    report_mismatch("word with none expected", result.hash_high, '0);
                end
                else
                begin
                    want = expected_hashes.pop_front();
                    if (result.hash_high !== want.hash_high)
                    begin
                        report_mismatch("hash_high", result.hash_high, want.hash_high);
                    end
                    if (result.hash_low !== want.hash_low)
                    begin
                        report_mismatch("hash_low", result.hash_low, want.hash_low);
                    end
                    if (result.hash_final !== want.hash_final)
                    begin
                        report_mismatch("hash_final", 64'(result.hash_final),
                                        64'(want.hash_final));
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL ghash_accumulator_top");
            $finish;
        end
    end

    initial
    begin
        logic [127:0] key;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // zero key
        load_hash_key('0);
        queue_block(ALL_ONES, ALL_ONES, 1'b0);
        queue_block(pick_half(), pick_half(), 1'b1);
        drain();

        // multiplicative identity
        load_hash_key({1'b1, 127'b0});
        queue_block('0, '0, 1'b0);
        queue_block(ALL_ONES, ALL_ONES, 1'b0);
        queue_block({1'b1, 63'b0}, '0, 1'b0);
        queue_block('0, 64'd1, 1'b1);
        queue_block(ALL_ONES, '0, 1'b1);
        drain();

        load_hash_key({ALL_ONES, ALL_ONES});
        queue_block(ALL_ONES, ALL_ONES, 1'b0);
        queue_block(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0);
        queue_block(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        queue_block('0, 64'd1, 1'b1);
        drain();

        // key changes while a message is open
        load_hash_key(128'd1);
        queue_block('0, 64'd1, 1'b0);
        queue_block(ALL_ONES, ALL_ONES, 1'b0);
        queue_block({1'b1, 63'b0}, '0, 1'b0);
        drain();
        load_hash_key({$urandom(), $urandom(), $urandom(), $urandom()});
        queue_block('0, '0, 1'b0);
        queue_block(ALL_ONES, '0, 1'b1);
        drain();

        for (int ph = 0; ph < 9; ph++)
        begin
            unique case (ph)
                0: key = {ALL_ONES, ALL_ONES};
                1: key = '0;
                2: key = {1'b1, 127'b0};
                3: key = 128'd1;
                default: key = {$urandom(), $urandom(), $urandom(), $urandom()};
            endcase
            idling_on = (ph != 8);
            load_hash_key(key);
            if (ph == 4)
            begin
                stall_request = 1'b1;
            end
            queue_messages(ph == 8 ? 150 : 110);
            drain();
        end

        repeat (8) @(negedge clk);
        if (expected_hashes.size() != 0)
        begin
            report_mismatch("words never returned", 64'(expected_hashes.size()), '0);
        end
        if (error_count == 0)
        begin
            $display("PASS ghash_accumulator_top");
        end
        else
        begin
            $display("FAIL ghash_accumulator_top");
        end
        $finish;
    end

endmodule

>>> ghash_accumulator_top.f
sv/ghac_pkg.sv
sv/ghac_queue.sv
sv/ghac_back.sv
sv/ghash_accumulator_top.sv
tb/tb_ghash_accumulator_top.sv
